[hdl/isrt_pkg.sv]
// isrt_pkg: shared constants and types of the insertion sort engine
// used by isrt_cell and insertion_sort_engine; no dependencies
package isrt_pkg;

   localparam int SET_DEPTH = 16;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = $clog2(SET_DEPTH + 1);

   // what a cell shows its neighbors
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              valid;
      logic              gt;
   } cell_link_type;

   // command to every cell of the chain at once
   typedef struct packed {
      logic insert;
      logic shift_out;
   } cell_ctrl_type;

endpackage

[hdl/isrt_cell.sv]
// isrt_cell: one compare-and-shift cell of the sorting chain
// depends on isrt_pkg for link and control types
module isrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  isrt_pkg::cell_ctrl_type     ctrl,
   input  logic [isrt_pkg::DATA_W-1:0] new_value,
   input  isrt_pkg::cell_link_type     left,
   input  isrt_pkg::cell_link_type     right,
   output isrt_pkg::cell_link_type     link
);

   logic [isrt_pkg::DATA_W-1:0] value_ff, value_in;
   logic                        valid_ff, valid_in;
   logic                        gt;

   // equal values are not greater, so a new value lands behind them
   assign gt = valid_ff && ($signed(value_ff) > $signed(new_value));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift_out) begin
         value_in = right.value;
         valid_in = right.valid;
      end else if (ctrl.insert && (gt || !valid_ff)) begin
         if (left.gt) begin
            value_in = left.value;
            valid_in = 1'b1;
         end else if (left.valid) begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign link.value = value_ff;
   assign link.valid = valid_ff;
   assign link.gt    = gt;

endmodule

[hdl/insertion_sort_engine.sv]
// insertion_sort_engine: stable ascending sorter built from a chain of isrt_cell
// depends on isrt_pkg and isrt_cell
//
//   channel  direction  ports                                            beat
//   req      in         req_valid req_ready req_value req_end_of_set     one element
//   rsp      out        rsp_valid rsp_ready rsp_sorted_value
//                       rsp_final_res rsp_overflow                       one sorted element
//
// while filling, one element is inserted per cycle: all cells compare at once and shift right
// a set drains at full rsp rate, the chain shifting toward cell 0
// req_ready is low while a set drains; the next set starts filling right after the final beat
// a stalled rsp beat holds in the output register and freezes the drain
// reset empties every cell at once, no clearing pass
module insertion_sort_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [isrt_pkg::DATA_W-1:0] req_value,
   input  logic                        req_end_of_set,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [isrt_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                        rsp_final_res,
   output logic                        rsp_overflow
);

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type                   state_ff, state_in;
   logic [isrt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        drop_ff, drop_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [isrt_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                        rsp_final_ff, rsp_final_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic                    accept, full, slot_free, shift, last_out;
   isrt_pkg::cell_ctrl_type ctrl;
   isrt_pkg::cell_link_type links [isrt_pkg::SET_DEPTH];
   isrt_pkg::cell_link_type head_link, tail_link;

   assign req_ready = (state_ff == ST_FILL);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == isrt_pkg::CNT_W'(isrt_pkg::SET_DEPTH));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign shift     = (state_ff == ST_DRAIN) && slot_free;
   assign last_out  = (count_ff == isrt_pkg::CNT_W'(1));

   assign ctrl.insert    = accept && !full;
   assign ctrl.shift_out = shift;

   // boundary in front of cell 0 takes the new value; nothing enters behind the last cell
   assign head_link.value = '0;
   assign head_link.valid = 1'b1;
   assign head_link.gt    = 1'b0;
   assign tail_link.value = '0;
   assign tail_link.valid = 1'b0;
   assign tail_link.gt    = 1'b0;

   for (genvar i = 0; i < isrt_pkg::SET_DEPTH; i++) begin : g_cell
      isrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_value (req_value),
         .left      ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
         .right     ((i == isrt_pkg::SET_DEPTH - 1) ? tail_link
                     : links[(i == isrt_pkg::SET_DEPTH - 1) ? i : i + 1]),
         .link      (links[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_FILL: begin
            if (accept) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  count_in = count_ff + isrt_pkg::CNT_W'(1);
               end
               if (req_end_of_set) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (shift) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = links[0].value;
               rsp_final_in = last_out;
               rsp_ovf_in   = drop_ff;
               count_in     = count_ff - isrt_pkg::CNT_W'(1);
               if (last_out) begin
                  drop_in  = 1'b0;
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_res    = rsp_final_ff;
   assign rsp_overflow     = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= isrt_pkg::CNT_W'(isrt_pkg::SET_DEPTH))
      else $error("held count beyond store depth");

   a_head_matches_count : assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) == links[0].valid)
      else $error("cell 0 occupancy disagrees with held count");

   a_drain_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("draining an empty chain");

   // the final beat leaves an empty chain behind it
   a_final_back_to_fill : assert property (@(posedge clock) disable iff (reset)
      (shift && last_out) |=> rsp_valid_ff && rsp_final_ff && (state_ff == ST_FILL)
                              && (count_ff == '0))
      else $error("final beat shown while chain still holds elements");

   a_chain_ordered : assert property (@(posedge clock) disable iff (reset)
      links[1].valid |-> (links[0].valid
                          && ($signed(links[0].value) <= $signed(links[1].value))))
      else $error("front of chain out of order");
`endif

endmodule

[sim/insertion_sort_engine_chk.sv]
// insertion_sort_engine_chk: watches the req and rsp channels, predicts the sorted beats
// and compares them; depends on isrt_pkg only
`timescale 1ns / 1ps
module insertion_sort_engine_chk (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [isrt_pkg::DATA_W-1:0] req_value,
   input  logic                        req_end_of_set,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [isrt_pkg::DATA_W-1:0] rsp_sorted_value,
   input  logic                        rsp_final_res,
   input  logic                        rsp_overflow,
   output int                          fail_count,
   output int                          pending
);

   typedef struct packed {
      logic [isrt_pkg::DATA_W-1:0] value;
      logic                        final_res;
      logic                        overflow;
   } sorted_beat_type;

   logic signed [isrt_pkg::DATA_W-1:0] shadow_store [isrt_pkg::SET_DEPTH];
   int                                 shadow_count;
   logic                               shadow_dropped;
   sorted_beat_type                    sorted_due [$];
   int                                 mismatches;

   // insert behind equal values; on the end mark queue the whole set in order
   task automatic absorb_element(input logic signed [isrt_pkg::DATA_W-1:0] v,
                                 input logic last);
      int pos;
      if (shadow_count >= isrt_pkg::SET_DEPTH) begin
         shadow_dropped = 1'b1;
      end else begin
         pos = shadow_count;
         while (pos > 0 && shadow_store[pos-1] > v) begin
            shadow_store[pos] = shadow_store[pos-1];
            pos--;
         end
         shadow_store[pos] = v;
         shadow_count++;
      end
      if (last) begin
         for (int k = 0; k < shadow_count; k++) begin
            sorted_due.push_back('{value: shadow_store[k],
                                   final_res: (k == shadow_count - 1),
                                   overflow: shadow_dropped});
         end
         shadow_count   = 0;
         shadow_dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      sorted_beat_type want;
      if (reset) begin
         shadow_count   = 0;
         shadow_dropped = 1'b0;
         mismatches     = 0;
         sorted_due.delete();
      end else begin
         // the rsp beat is checked before a req beat of the same edge adds to the queue
         if (rsp_valid && rsp_ready) begin
            if (sorted_due.size() == 0) begin
               $error("unexpected sorted beat, sorted_value %0d", $signed(rsp_sorted_value));
               mismatches++;
            end else begin
               want = sorted_due.pop_front();
               if (rsp_sorted_value !== want.value) begin
                  $error("sorted_value: expected %0d, actual %0d",
                         $signed(want.value), $signed(rsp_sorted_value));
                  mismatches++;
               end
               if (rsp_final_res !== want.final_res) begin
                  $error("final_res: expected %0b, actual %0b", want.final_res, rsp_final_res);
                  mismatches++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0b, actual %0b", want.overflow, rsp_overflow);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            absorb_element(req_value, req_end_of_set);
      end
      fail_count <= mismatches;
      pending    <= sorted_due.size();
   end

endmodule

[sim/insertion_sort_engine_tb.sv]
// insertion_sort_engine_tb: drives sets of signed values into the sorter with random gaps
// and rsp stalls; depends on isrt_pkg, insertion_sort_engine and insertion_sort_engine_chk
`timescale 1ns / 1ps
module insertion_sort_engine_tb;

   localparam int IDLE_LIMIT  = 2000;
   localparam int RANDOM_BEATS = 470;
   localparam logic [isrt_pkg::DATA_W-1:0] CORNER_VALS [6] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
      32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0005
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [isrt_pkg::DATA_W-1:0] req_value = '0;
   logic                        req_end_of_set = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [isrt_pkg::DATA_W-1:0] rsp_sorted_value;
   logic                        rsp_final_res;
   logic                        rsp_overflow;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int rsp_hold = 0;
   bit rsp_burst = 1'b0;
   bit send_burst = 1'b0;
   int beats_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   insertion_sort_engine uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_end_of_set   (req_end_of_set),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_overflow     (rsp_overflow)
   );

   insertion_sort_engine_chk chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_end_of_set   (req_end_of_set),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_overflow     (rsp_overflow),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // receiver: a fresh stall per beat, with occasional stretches of none
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 19) == 0)
            rsp_burst <= !rsp_burst;
         w = rsp_burst ? 0 : $urandom_range(0, 13);
         rsp_hold  <= w;
         rsp_ready <= (w == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_element(input logic [isrt_pkg::DATA_W-1:0] v, input logic last);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value      <= v;
      req_end_of_set <= last;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // pending is registered and lags the queue, so look only after the next edge
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int set_len;
      int pick;
      logic [isrt_pkg::DATA_W-1:0] v;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of the signed range plus a duplicate pair
      foreach (CORNER_VALS[i])
         send_element(CORNER_VALS[i], i == 5);
      // a set of one
      send_element(32'hFFFF_FFFE, 1'b1);
      // full store, then an end-marked value that is dropped
      for (int i = 0; i < isrt_pkg::SET_DEPTH; i++)
         send_element(-(i / 2), 1'b0);
      send_element(32'h8000_0000, 1'b1);
      wait_drained();

      while (beats_sent < RANDOM_BEATS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            set_len = $urandom_range(isrt_pkg::SET_DEPTH + 1, isrt_pkg::SET_DEPTH + 6);
         else if (pick < 4)
            set_len = 1;
         else
            set_len = $urandom_range(2, isrt_pkg::SET_DEPTH);
         send_burst = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < set_len; i++) begin
            case ($urandom_range(0, 9))
               0:       v = CORNER_VALS[$urandom_range(0, 3)];
               1, 2, 3: v = $urandom_range(0, 15) - 8;  // dense values give duplicates
               default: v = $urandom;
            endcase
            send_element(v, i == set_len - 1);
         end
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
hdl/isrt_pkg.sv
hdl/isrt_cell.sv
hdl/insertion_sort_engine.sv
sim/insertion_sort_engine_chk.sv
sim/insertion_sort_engine_tb.sv
